@@ hw/rtl/serial_servo_command_parser_assert.svh @@
// Assertion macros shared by the servo command parser RTL.
`ifndef SERIAL_SERVO_COMMAND_PARSER_ASSERT_SVH
`define SERIAL_SERVO_COMMAND_PARSER_ASSERT_SVH
`ifndef ASSERT_OFF
`define SSCP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SSCP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SSCP_ASSERT(label, prop, msg)
`define SSCP_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

@@ hw/rtl/sscp_pkg.sv @@
// Types and constants of the serial servo command parser.
`timescale 1ns / 1ps
`default_nettype none
package sscp_pkg;

  // Command and frame characters
  localparam logic [7:0] CH_END   = 8'h5F;  // '_'
  localparam logic [7:0] CH_LASER = 8'h4C;  // 'L'
  localparam logic [7:0] CH_AUTO  = 8'h52;  // 'R'
  localparam logic [7:0] CH_LOW   = 8'h41;  // 'A'
  localparam logic [7:0] CH_HIGH  = 8'h42;  // 'B'
  localparam logic [7:0] CH_Y     = 8'h59;  // 'Y'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MAX = 2'd1;

  // Reset values
  localparam logic [15:0] RST_PULSE_MIN = 16'd650;
  localparam logic [15:0] RST_PULSE_MAX = 16'd2400;
  localparam logic [15:0] RST_PULSE     = 16'd1500;
  localparam logic [15:0] RST_LOW_X     = 16'd1500;
  localparam logic [15:0] RST_LOW_Y     = 16'd700;
  localparam logic [15:0] RST_HIGH_X    = 16'd2350;
  localparam logic [15:0] RST_HIGH_Y    = 16'd2350;

  typedef struct packed {
    logic        frame_done;
    logic [15:0] frame_x;
    logic [15:0] frame_y;
    logic [15:0] servo_x;
    logic [15:0] servo_y;
    logic        laser_on;
    logic        auto_mode;
    logic [15:0] area_x_low;
    logic [15:0] area_y_low;
    logic [15:0] area_x_high;
    logic [15:0] area_y_high;
  } status_t;

endpackage
`default_nettype wire

@@ hw/rtl/sscp_parser.sv @@
// Frame parser and command state; its registers are the result register.
`timescale 1ns / 1ps
`default_nettype none
module sscp_parser #(
  parameter int unsigned MAX_FRAME_BYTES = 12
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire logic [7:0]       rx_byte,
  input  wire logic             line_error,
  input  wire logic [15:0]      pulse_min,
  input  wire logic [15:0]      pulse_max,
  output sscp_pkg::status_t     status
);

  localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_FRAME_BYTES - 1);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_X    = 2'd1;
  localparam logic [1:0] PH_Y    = 2'd2;

  logic [1:0]       phase_r, phase_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [15:0]      xacc_r, xacc_nxt;
  logic [15:0]      yacc_r, yacc_nxt;
  logic [15:0]      last_x_r, last_x_nxt;
  logic [15:0]      last_y_r, last_y_nxt;
  logic [15:0]      pulse_x_r, pulse_x_nxt;
  logic [15:0]      pulse_y_r, pulse_y_nxt;
  logic             laser_r, laser_nxt;
  logic             auto_r, auto_nxt;
  logic [15:0]      low_x_r, low_x_nxt;
  logic [15:0]      low_y_r, low_y_nxt;
  logic [15:0]      high_x_r, high_x_nxt;
  logic [15:0]      high_y_r, high_y_nxt;
  logic             done_r, done_nxt;

  logic        digit;
  logic [15:0] digit_val;
  logic [15:0] x_dec;
  logic [15:0] y_dec;

  assign digit     = rx_byte inside {[sscp_pkg::CH_ZERO:sscp_pkg::CH_NINE]};
  assign digit_val = {12'd0, rx_byte[3:0]};
  // Times ten as two shifts and an add; the sum wraps at 16 bits.
  assign x_dec = (xacc_r << 3) + (xacc_r << 1) + digit_val;
  assign y_dec = (yacc_r << 3) + (yacc_r << 1) + digit_val;

  always_comb begin
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    xacc_nxt    = xacc_r;
    yacc_nxt    = yacc_r;
    last_x_nxt  = last_x_r;
    last_y_nxt  = last_y_r;
    pulse_x_nxt = pulse_x_r;
    pulse_y_nxt = pulse_y_r;
    laser_nxt   = laser_r;
    auto_nxt    = auto_r;
    low_x_nxt   = low_x_r;
    low_y_nxt   = low_y_r;
    high_x_nxt  = high_x_r;
    high_y_nxt  = high_y_r;
    done_nxt    = done_r;
    if (step) begin
      done_nxt = 1'b0;
      if (!line_error) begin
        case (rx_byte)
          sscp_pkg::CH_END: begin
            if (phase_r == PH_Y) begin
              last_x_nxt = xacc_r;
              last_y_nxt = yacc_r;
              if (xacc_r >= pulse_min && xacc_r <= pulse_max) begin
                pulse_x_nxt = xacc_r;
              end
              if (yacc_r >= pulse_min && yacc_r <= pulse_max) begin
                pulse_y_nxt = yacc_r;
              end
              done_nxt = 1'b1;
            end
            phase_nxt = PH_IDLE;
            cnt_nxt   = '0;
            xacc_nxt  = '0;
            yacc_nxt  = '0;
          end
          sscp_pkg::CH_LASER: laser_nxt = ~laser_r;
          sscp_pkg::CH_AUTO:  auto_nxt  = ~auto_r;
          sscp_pkg::CH_LOW: begin
            low_x_nxt = last_x_r;
            low_y_nxt = last_y_r;
          end
          sscp_pkg::CH_HIGH: begin
            high_x_nxt = last_x_r;
            high_y_nxt = last_y_r;
          end
          default: begin
            case (phase_r)
              PH_IDLE: phase_nxt = PH_X;
              PH_X: begin
                if (rx_byte == sscp_pkg::CH_Y) begin
                  phase_nxt = PH_Y;
                end else if (digit) begin
                  xacc_nxt = x_dec;
                end
              end
              default: begin
                if (digit) begin
                  yacc_nxt = y_dec;
                end
              end
            endcase
            // A frame that fills up without an underscore is thrown away.
            if (cnt_r == CNT_LAST) begin
              phase_nxt = PH_IDLE;
              cnt_nxt   = '0;
              xacc_nxt  = '0;
              yacc_nxt  = '0;
            end else begin
              cnt_nxt = cnt_r + 1'b1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      cnt_r     <= '0;
      xacc_r    <= '0;
      yacc_r    <= '0;
      last_x_r  <= '0;
      last_y_r  <= '0;
      pulse_x_r <= sscp_pkg::RST_PULSE;
      pulse_y_r <= sscp_pkg::RST_PULSE;
      laser_r   <= 1'b1;
      auto_r    <= 1'b1;
      low_x_r   <= sscp_pkg::RST_LOW_X;
      low_y_r   <= sscp_pkg::RST_LOW_Y;
      high_x_r  <= sscp_pkg::RST_HIGH_X;
      high_y_r  <= sscp_pkg::RST_HIGH_Y;
      done_r    <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      cnt_r     <= cnt_nxt;
      xacc_r    <= xacc_nxt;
      yacc_r    <= yacc_nxt;
      last_x_r  <= last_x_nxt;
      last_y_r  <= last_y_nxt;
      pulse_x_r <= pulse_x_nxt;
      pulse_y_r <= pulse_y_nxt;
      laser_r   <= laser_nxt;
      auto_r    <= auto_nxt;
      low_x_r   <= low_x_nxt;
      low_y_r   <= low_y_nxt;
      high_x_r  <= high_x_nxt;
      high_y_r  <= high_y_nxt;
      done_r    <= done_nxt;
    end
  end

  assign status.frame_done  = done_r;
  assign status.frame_x     = last_x_r;
  assign status.frame_y     = last_y_r;
  assign status.servo_x     = pulse_x_r;
  assign status.servo_y     = pulse_y_r;
  assign status.laser_on    = laser_r;
  assign status.auto_mode   = auto_r;
  assign status.area_x_low  = low_x_r;
  assign status.area_y_low  = low_y_r;
  assign status.area_x_high = high_x_r;
  assign status.area_y_high = high_y_r;

`include "serial_servo_command_parser_assert.svh"

  `SSCP_ASSERT(a_done_clears, done_r |-> (phase_r == PH_IDLE && cnt_r == '0), "frame not cleared")
  `SSCP_ASSERT(a_idle_empty, (phase_r == PH_IDLE) |-> (cnt_r == '0 && xacc_r == '0), "idle frame holds data")
  `SSCP_ASSERT_NEXT(a_hold, !step, $stable(status) && $stable(phase_r), "state moved without a step")

endmodule
`default_nettype wire

@@ hw/rtl/serial_servo_command_parser.sv @@
// Top level of the serial servo command parser: handshakes, input register, configuration.
// A byte is held in the input register and then moves into the parser state, which doubles as
// the result register; while the result is stalled, the byte waits in the input register.
// Throughput: one byte per cycle while the result is not stalled; the parser state updates once per byte.
// Reset (synchronous, active low) restores the pulse limits, servo pulses, flags and area
// corners to their defaults and empties both pipeline registers.
`timescale 1ns / 1ps
`default_nettype none
module serial_servo_command_parser #(
  parameter int unsigned MAX_FRAME_BYTES = 12
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [7:0]                     in_rx_byte,
  input  wire logic                           in_line_error,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_frame_done,
  output logic [15:0]                         out_frame_x,
  output logic [15:0]                         out_frame_y,
  output logic [15:0]                         out_servo_x,
  output logic [15:0]                         out_servo_y,
  output logic                                out_laser_on,
  output logic                                out_auto_mode,
  output logic [15:0]                         out_area_x_low,
  output logic [15:0]                         out_area_y_low,
  output logic [15:0]                         out_area_x_high,
  output logic [15:0]                         out_area_y_high,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [sscp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                    cfg_data
);

  logic        in_valid_r, in_valid_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        err_r, err_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] pulse_min_r, pulse_min_nxt;
  logic [15:0] pulse_max_r, pulse_max_nxt;
  logic        in_take;
  logic        move;
  sscp_pkg::status_t status;

  // The held byte moves on whenever the result register is empty or being read.
  assign move     = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    in_valid_nxt  = in_valid_r;
    byte_nxt      = byte_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r;
    pulse_min_nxt = pulse_min_r;
    pulse_max_nxt = pulse_max_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
      byte_nxt     = in_rx_byte;
      err_nxt      = in_line_error;
    end else if (move) begin
      in_valid_nxt = 1'b0;
    end
    if (move) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sscp_pkg::CFG_PULSE_MIN: pulse_min_nxt = cfg_data;
        sscp_pkg::CFG_PULSE_MAX: pulse_max_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pulse_min_r <= sscp_pkg::RST_PULSE_MIN;
      pulse_max_r <= sscp_pkg::RST_PULSE_MAX;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      pulse_min_r <= pulse_min_nxt;
      pulse_max_r <= pulse_max_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    err_r  <= err_nxt;
  end

  sscp_parser #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (move),
    .rx_byte   (byte_r),
    .line_error(err_r),
    .pulse_min (pulse_min_r),
    .pulse_max (pulse_max_r),
    .status    (status)
  );

  assign out_valid       = out_valid_r;
  assign out_frame_done  = status.frame_done;
  assign out_frame_x     = status.frame_x;
  assign out_frame_y     = status.frame_y;
  assign out_servo_x     = status.servo_x;
  assign out_servo_y     = status.servo_y;
  assign out_laser_on    = status.laser_on;
  assign out_auto_mode   = status.auto_mode;
  assign out_area_x_low  = status.area_x_low;
  assign out_area_y_low  = status.area_y_low;
  assign out_area_x_high = status.area_x_high;
  assign out_area_y_high = status.area_y_high;

`include "serial_servo_command_parser_assert.svh"

  `SSCP_ASSERT_NEXT(a_held_byte_kept, in_valid_r && !move, in_valid_r && $stable(byte_r), "held byte lost")
  `SSCP_ASSERT_NEXT(a_move_offers, move, out_valid_r, "processed byte gave no result")
  `SSCP_ASSERT(a_stall_no_step, (out_valid_r && out_stall) |-> !move, "result overwritten while stalled")

endmodule
`default_nettype wire

@@ test/serial_servo_command_parser_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the serial servo command parser, with a status predictor.
module serial_servo_command_parser_tb;
  import sscp_pkg::*;

  localparam int unsigned FRAME_BYTES = 12;
  localparam int unsigned PHASES = 8;
  localparam int unsigned ITEMS_PER_PHASE = 105;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum logic [1:0] {SEEK_START, READ_X, READ_Y} parse_phase_t;

  class status_scoreboard;
    logic [15:0]  lim_lo;
    logic [15:0]  lim_hi;
    parse_phase_t phase;
    int unsigned  frame_len;
    logic [15:0]  acc_x;
    logic [15:0]  acc_y;
    logic [15:0]  parsed_x;
    logic [15:0]  parsed_y;
    logic [15:0]  pulse_x;
    logic [15:0]  pulse_y;
    logic         laser;
    logic         auto_run;
    logic [15:0]  low_x;
    logic [15:0]  low_y;
    logic [15:0]  high_x;
    logic [15:0]  high_y;
    status_t      status_due[$];
    int unsigned  mismatches;

    function new();
      lim_lo = RST_PULSE_MIN;
      lim_hi = RST_PULSE_MAX;
      drop_frame();
      parsed_x = '0;
      parsed_y = '0;
      pulse_x = RST_PULSE;
      pulse_y = RST_PULSE;
      laser = 1'b1;
      auto_run = 1'b1;
      low_x = RST_LOW_X;
      low_y = RST_LOW_Y;
      high_x = RST_HIGH_X;
      high_y = RST_HIGH_Y;
      mismatches = 0;
    endfunction

    function void drop_frame();
      phase = SEEK_START;
      frame_len = 0;
      acc_x = '0;
      acc_y = '0;
    endfunction

    function bit fits(logic [15:0] v);
      return (v >= lim_lo) && (v <= lim_hi);
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
      case (idx)
        CFG_PULSE_MIN: lim_lo = data;
        CFG_PULSE_MAX: lim_hi = data;
        default: ;
      endcase
    endfunction

    // Works out the status that the block reports after this byte.
    function void take_byte(logic [7:0] c, logic err);
      status_t e;
      logic    digit;
      e = '0;
      digit = (c >= CH_ZERO) && (c <= CH_NINE);
      if (!err) begin
        case (c)
          CH_END: begin
            if (phase == READ_Y) begin
              parsed_x = acc_x;
              parsed_y = acc_y;
              if (fits(acc_x)) pulse_x = acc_x;
              if (fits(acc_y)) pulse_y = acc_y;
              e.frame_done = 1'b1;
            end
            drop_frame();
          end
          CH_LASER: laser = ~laser;
          CH_AUTO: auto_run = ~auto_run;
          CH_LOW: begin
            low_x = parsed_x;
            low_y = parsed_y;
          end
          CH_HIGH: begin
            high_x = parsed_x;
            high_y = parsed_y;
          end
          default: begin
            // The opening byte of a frame is skipped, whatever it is, unless it is a command or an underscore.
            case (phase)
              SEEK_START: phase = READ_X;
              READ_X: begin
                if (c == CH_Y) phase = READ_Y;
                else if (digit) acc_x = acc_x * 16'd10 + 16'(c - CH_ZERO);
              end
              default: if (digit) acc_y = acc_y * 16'd10 + 16'(c - CH_ZERO);
            endcase
            frame_len++;
            if (frame_len >= FRAME_BYTES) drop_frame();
          end
        endcase
      end
      e.frame_x = parsed_x;
      e.frame_y = parsed_y;
      e.servo_x = pulse_x;
      e.servo_y = pulse_y;
      e.laser_on = laser;
      e.auto_mode = auto_run;
      e.area_x_low = low_x;
      e.area_y_low = low_y;
      e.area_x_high = high_x;
      e.area_y_high = high_y;
      status_due.push_back(e);
    endfunction

    task report(string msg);
      mismatches++;
      $display("ERROR at %0t: %s", $time, msg);
    endtask

    task check_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) report($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    task match_status(status_t got);
      status_t want;
      if (status_due.size() == 0) begin
        report("status transaction arrived with none expected");
        return;
      end
      want = status_due.pop_front();
      check_field("frame_done", 16'(got.frame_done), 16'(want.frame_done));
      check_field("frame_x", got.frame_x, want.frame_x);
      check_field("frame_y", got.frame_y, want.frame_y);
      check_field("servo_x", got.servo_x, want.servo_x);
      check_field("servo_y", got.servo_y, want.servo_y);
      check_field("laser_on", 16'(got.laser_on), 16'(want.laser_on));
      check_field("auto_mode", 16'(got.auto_mode), 16'(want.auto_mode));
      check_field("area_x_low", got.area_x_low, want.area_x_low);
      check_field("area_y_low", got.area_y_low, want.area_y_low);
      check_field("area_x_high", got.area_x_high, want.area_x_high);
      check_field("area_y_high", got.area_y_high, want.area_y_high);
    endtask
  endclass

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_rx_byte = '0;
  logic                 in_line_error = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_frame_done;
  logic [15:0]          out_frame_x;
  logic [15:0]          out_frame_y;
  logic [15:0]          out_servo_x;
  logic [15:0]          out_servo_y;
  logic                 out_laser_on;
  logic                 out_auto_mode;
  logic [15:0]          out_area_x_low;
  logic [15:0]          out_area_y_low;
  logic [15:0]          out_area_x_high;
  logic [15:0]          out_area_y_high;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_PULSE_MIN;
  logic [15:0]          cfg_data = '0;

  status_scoreboard sb = new();
  bit               tx_steady = 1'b0;
  bit               rx_steady = 1'b0;
  int unsigned      clean_items = 0;
  int unsigned      idle_cycles = 0;

  serial_servo_command_parser #(
    .MAX_FRAME_BYTES(FRAME_BYTES)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .in_line_error  (in_line_error),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame_done (out_frame_done),
    .out_frame_x    (out_frame_x),
    .out_frame_y    (out_frame_y),
    .out_servo_x    (out_servo_x),
    .out_servo_y    (out_servo_y),
    .out_laser_on   (out_laser_on),
    .out_auto_mode  (out_auto_mode),
    .out_area_x_low (out_area_x_low),
    .out_area_y_low (out_area_y_low),
    .out_area_x_high(out_area_x_high),
    .out_area_y_high(out_area_y_high),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned draw_gap(bit steady);
    return steady ? 0 : $urandom_range(14, 0);
  endfunction

  function automatic logic line_noise();
    return $urandom_range(15, 0) == 0;
  endfunction

  function automatic logic [7:0] pick_command();
    case ($urandom_range(3, 0))
      0: return CH_LASER;
      1: return CH_AUTO;
      2: return CH_LOW;
      default: return CH_HIGH;
    endcase
  endfunction

  // Decimal text for one axis: empty, inside the limits (when ordered), anywhere in 16 bits, wrapping, or up to 3000.
  function automatic string axis_digits();
    int unsigned v;
    case ($urandom_range(4, 0))
      0: return "";
      1: v = (sb.lim_lo <= sb.lim_hi) ? $urandom_range(sb.lim_hi, sb.lim_lo)
                                      : $urandom_range(65535, 0);
      2: v = $urandom_range(65535, 0);
      3: v = $urandom_range(999999, 65536);
      default: v = $urandom_range(3000, 0);
    endcase
    return $sformatf("%0d", v);
  endfunction

  // Valid stays high into the next transaction when no gap is drawn.
  task automatic send_byte(input logic [7:0] c, input logic err);
    int unsigned gap;
    gap = draw_gap(tx_steady);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= c;
    in_line_error <= err;
    do @(posedge clk); while (in_stall);
    sb.take_byte(c, err);
    if (!err) clean_items++;
  endtask

  task automatic send_text(input string s, input bit noisy);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], noisy ? line_noise() : 1'b0);
  endtask

  task automatic send_frame();
    string      x_txt;
    string      y_txt;
    logic [7:0] lead;
    x_txt = axis_digits();
    y_txt = axis_digits();
    lead = $urandom_range(1, 0) ? 8'h58 : 8'($urandom_range(255, 0));
    send_byte(lead, line_noise());
    send_text(x_txt, 1'b1);
    if ($urandom_range(7, 0) == 0) send_byte(pick_command(), 1'b0);
    send_byte(CH_Y, line_noise());
    // A stray comma or a second Y is counted but leaves the value alone.
    if ($urandom_range(7, 0) == 0) send_byte($urandom_range(1, 0) ? CH_Y : 8'h2C, 1'b0);
    send_text(y_txt, 1'b1);
    send_byte(CH_END, line_noise());
  endtask

  task automatic put_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_register(idx, data);
  endtask

  task automatic set_limits(input logic [15:0] lo, input logic [15:0] hi, input bit spare);
    put_register(CFG_PULSE_MIN, lo);
    put_register(CFG_PULSE_MAX, hi);
    if (spare) put_register(CFG_SPARE, 16'($urandom_range(65535, 0)));
    cfg_valid <= 1'b0;
  endtask

  // Holds the sender back until every status transaction has come in.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.status_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : result_sink
    int unsigned gap;
    forever begin
      gap = draw_gap(rx_steady);
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      sb.match_status({out_frame_done, out_frame_x, out_frame_y, out_servo_x, out_servo_y,
                       out_laser_on, out_auto_mode, out_area_x_low, out_area_y_low,
                       out_area_x_high, out_area_y_high});
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [15:0] lo;
    logic [15:0] hi;
    int unsigned target;
    int unsigned pick;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Errored bytes first, then commands, short frames and an overlong one.
    send_byte(CH_LASER, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_text("LR", 1'b0);
    send_text("Y2Y3_", 1'b0);
    send_byte(CH_LOW, 1'b0);
    send_text("XL7_", 1'b0);
    send_byte(8'h00, 1'b0);
    send_text("99999999999", 1'b0);
    send_byte(CH_HIGH, 1'b0);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin lo = 16'd0;     hi = 16'd65535; end
        1: begin lo = 16'd0;     hi = 16'd0;     end
        2: begin lo = 16'd65535; hi = 16'd65535; end
        3: begin lo = 16'd3000;  hi = 16'd1000;  end
        4: begin lo = RST_PULSE_MIN; hi = RST_PULSE_MAX; end
        default: begin
          lo = 16'($urandom_range(65535, 0));
          hi = 16'($urandom_range(65535, 0));
        end
      endcase
      set_limits(lo, hi, p == 3);
      tx_steady = ($urandom_range(3, 0) == 0);
      rx_steady = ($urandom_range(3, 0) == 0);
      target = clean_items + ITEMS_PER_PHASE;
      while (clean_items < target) begin
        pick = $urandom_range(19, 0);
        if (pick < 14) send_frame();
        else if (pick < 17) send_byte(pick_command(), line_noise());
        else send_byte(8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)));
      end
      settle();
    end

    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ serial_servo_command_parser.f @@
+incdir+hw/rtl
hw/rtl/sscp_pkg.sv
hw/rtl/sscp_parser.sv
hw/rtl/serial_servo_command_parser.sv
test/serial_servo_command_parser_tb.sv
